>>> rtl/fbte_pkg.sv
// Package for the framebuffer text and fill engine.
// Holds command codes, controller states, and the control/status structs.
// No dependencies.
package fbte_pkg;

  localparam int unsigned DefScreenWidth  = 320;
  localparam int unsigned DefScreenHeight = 240;
  localparam int unsigned DefGlyphBytes   = 4096;

  localparam int unsigned XW         = 12;  // loop coordinate width
  localparam int unsigned FirstCode  = 32;  // code of the first glyph in memory
  localparam int unsigned GPW        = 18;  // glyph byte pointer width

  typedef enum logic [2:0] {
    CMD_FILL      = 3'd0,
    CMD_RECT      = 3'd1,
    CMD_PIXEL     = 3'd2,
    CMD_GLYPH     = 3'd3,
    CMD_STR_START = 3'd4,
    CMD_STR_CHAR  = 3'd5,
    CMD_GLOAD     = 3'd6,
    CMD_READ      = 3'd7
  } cmd_e;

  typedef enum logic [0:0] {
    CFG_FONT_WIDTH  = 1'b0,
    CFG_FONT_HEIGHT = 1'b1
  } cfg_e;

  typedef enum logic [3:0] {
    ST_CLR_SET,
    ST_CLR_RUN,
    ST_IDLE,
    ST_PREP,
    ST_SETUP,
    ST_CHECK,
    ST_RUN,
    ST_READ,
    ST_FINISH,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;       // latch the input item
    logic clr_setup;  // arm the post-reset clearing sweep
    logic prep;       // cursor wrap for string characters
    logic setup;      // loop bounds, products, simple writes
    logic check;      // capture skip flag
    logic step;       // advance the pixel loop
    logic rd;         // issue the framebuffer read
    logic finish;     // capture the result, advance cursor
  } ctl_t;

  typedef struct packed {
    cmd_e cmd;
    logic skip;
    logic empty;
    logic last;
  } sts_t;

  function automatic logic [15:0] swap16(input logic [15:0] c);
    return {c[7:0], c[15:8]};
  endfunction

endpackage

>>> rtl/framebuffer_text_and_fill_engine.sv
// Top level of the framebuffer text and fill engine.
// Instantiates fbte_ctrl and fbte_dp; uses fbte_pkg.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o) takes one command item; an item
//    is taken on a clock edge with valid high and stall low.
//  - Output channel (out_valid_o / out_stall_i) returns exactly one result
//    item per command; the result holds while the receiver stalls, and the
//    next input item is taken once the result has been delivered.
//  - Configuration port (cfg_valid_i / cfg_ready_o) sets font width (index 0)
//    and font height (index 1); always ready, write it only while idle.
//  - String start, glyph load and skipped or empty drawings run no pixel
//    loop; read issues one framebuffer read; pixel, glyphs and rectangles
//    loop over their pixels (whole glyph, clipped or not; rectangle
//    clipped to the screen), and a fill over the whole screen. The loop
//    writes one pixel per cycle.
//  - Reset: the font registers return to 8x8, cursor and origin to zero, and
//    the block sweeps the framebuffer to zero, one pixel per cycle, holding
//    in_stall_o high meanwhile.
module framebuffer_text_and_fill_engine
  import fbte_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = DefScreenWidth,
  parameter int unsigned SCREEN_HEIGHT = DefScreenHeight,
  parameter int unsigned GLYPH_BYTES   = DefGlyphBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [9:0]  x_first_i,
  input  logic [9:0]  y_first_i,
  input  logic [10:0] x_end_i,
  input  logic [10:0] y_end_i,
  input  logic [15:0] colour_fore_i,
  input  logic [15:0] colour_back_i,
  input  logic        see_through_i,
  input  logic [7:0]  char_code_i,
  input  logic [11:0] glyph_address_i,
  input  logic [7:0]  glyph_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] pixel_value_o,
  output logic        status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [5:0]  cfg_data_i
);

  ctl_t ctl;
  sts_t sts;

  // Font registers accept a write in any cycle
  assign cfg_ready_o = 1'b1;

  fbte_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  fbte_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .GLYPH_BYTES   (GLYPH_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .command_i       (command_i),
    .x_first_i       (x_first_i),
    .y_first_i       (y_first_i),
    .x_end_i         (x_end_i),
    .y_end_i         (y_end_i),
    .colour_fore_i   (colour_fore_i),
    .colour_back_i   (colour_back_i),
    .see_through_i   (see_through_i),
    .char_code_i     (char_code_i),
    .glyph_address_i (glyph_address_i),
    .glyph_byte_i    (glyph_byte_i),
    .pixel_value_o   (pixel_value_o),
    .status_o        (status_o)
  );

endmodule

>>> rtl/fbte_ctrl.sv
// Controller state machine of the framebuffer text and fill engine.
// Depends on fbte_pkg; drives the datapath through ctl_t, reads sts_t.
module fbte_ctrl
  import fbte_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR_SET;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctl_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_CLR_SET: begin
        ctl_o.clr_setup = 1'b1;
        state_d = ST_CLR_RUN;
      end
      ST_CLR_RUN: begin
        ctl_o.step = 1'b1;
        if (sts_i.last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        ctl_o.prep = 1'b1;
        state_d = ST_SETUP;
      end
      ST_SETUP: begin
        ctl_o.setup = 1'b1;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        ctl_o.check = 1'b1;
        unique case (sts_i.cmd)
          CMD_STR_START, CMD_GLOAD: state_d = ST_FINISH;
          CMD_READ:                 state_d = ST_READ;
          default: begin
            if (sts_i.skip || sts_i.empty) state_d = ST_FINISH;
            else state_d = ST_RUN;
          end
        endcase
      end
      ST_RUN: begin
        ctl_o.step = 1'b1;
        if (sts_i.last) state_d = ST_FINISH;
      end
      ST_READ: begin
        ctl_o.rd = 1'b1;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        ctl_o.finish = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/fbte_dp.sv
// Datapath of the framebuffer text and fill engine: item registers, font
// registers, cursor, pixel loop, glyph memory and framebuffer. Uses fbte_pkg.
module fbte_dp
  import fbte_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = DefScreenWidth,
  parameter int unsigned SCREEN_HEIGHT = DefScreenHeight,
  parameter int unsigned GLYPH_BYTES   = DefGlyphBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctl_t        ctl_i,
  output sts_t        sts_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [5:0]  cfg_data_i,
  input  logic [2:0]  command_i,
  input  logic [9:0]  x_first_i,
  input  logic [9:0]  y_first_i,
  input  logic [10:0] x_end_i,
  input  logic [10:0] y_end_i,
  input  logic [15:0] colour_fore_i,
  input  logic [15:0] colour_back_i,
  input  logic        see_through_i,
  input  logic [7:0]  char_code_i,
  input  logic [11:0] glyph_address_i,
  input  logic [7:0]  glyph_byte_i,
  output logic [15:0] pixel_value_o,
  output logic        status_o
);

  localparam int unsigned Pixels = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned FAW    = $clog2(Pixels);
  localparam int unsigned GAW    = $clog2(GLYPH_BYTES);
  localparam int unsigned RBW    = XW + $clog2(SCREEN_WIDTH + 1);

  // Item registers
  cmd_e        cmd_q;
  logic [9:0]  xf_q, yf_q;
  logic [10:0] xe_q, ye_q;
  logic [15:0] fore_q, back_q;
  logic        clr_q;
  logic [7:0]  code_q;
  logic [11:0] gaddr_q;
  logic [7:0]  gbyte_in_q;

  // Font and cursor
  logic [5:0]  fw_q, fh_q;
  logic [9:0]  gsize_q;
  logic [10:0] cur_col_q, cur_row_q;
  logic [9:0]  org_col_q, org_row_q;

  // Pixel loop
  logic [XW-1:0]  x_q, xs_q, xstop_q, y_q, ystop_q;
  logic [RBW-1:0] rowbase_q;
  logic [GPW-1:0] gptr_q;
  logic [5:0]     c_q;
  logic [15:0]    pcol_q;
  logic           gmode_q, skip_q;

  // Write stage
  logic           pv_q, pin_q, pglyph_q;
  logic [FAW-1:0] pa_q;
  logic [2:0]     pbit_q;
  logic [7:0]     gbyte_q;

  logic [15:0] frd_q;
  logic [15:0] pixel_q;
  logic        status_q;

  logic [15:0] fmem [Pixels];
  logic [7:0]  gmem [GLYPH_BYTES];

  logic [3:0]  row_bytes;
  logic        gaddr_ok, rd_on_screen, skip_now, empty_now;
  logic        x_wrap, y_wrap;
  logic [XW-1:0] xs_s, ys_s, xstop_s, ystop_s;
  logic [10:0] col_a, row_a;
  logic        wr_bit, we;
  logic [15:0] wdata;

  assign row_bytes    = 4'((7'(fw_q) + 7'd7) >> 3);
  assign gaddr_ok     = 17'(gaddr_q) < 17'(GLYPH_BYTES);
  assign rd_on_screen = (11'(xf_q) < 11'(SCREEN_WIDTH)) && (11'(yf_q) < 11'(SCREEN_HEIGHT));
  assign skip_now     = gmode_q && ((code_q < 8'(FirstCode)) ||
                        ((19'(gptr_q) + 19'(gsize_q)) > 19'(GLYPH_BYTES)));
  assign empty_now    = (xs_q >= xstop_q) || (y_q >= ystop_q);
  assign x_wrap       = (x_q + 1'b1) == xstop_q;
  assign y_wrap       = (y_q + 1'b1) == ystop_q;

  assign sts_o.cmd   = cmd_q;
  assign sts_o.skip  = skip_now;
  assign sts_o.empty = empty_now;
  assign sts_o.last  = x_wrap && y_wrap;

  // Loop bounds per command
  always_comb begin
    xs_s    = XW'(xf_q);
    ys_s    = XW'(yf_q);
    xstop_s = XW'(xf_q) + 1'b1;
    ystop_s = XW'(yf_q) + 1'b1;
    case (cmd_q)
      CMD_FILL: begin
        xs_s    = '0;
        ys_s    = '0;
        xstop_s = XW'(SCREEN_WIDTH);
        ystop_s = XW'(SCREEN_HEIGHT);
      end
      CMD_RECT: begin
        xstop_s = (xe_q > 11'(SCREEN_WIDTH)) ? XW'(SCREEN_WIDTH) : XW'(xe_q);
        ystop_s = (ye_q > 11'(SCREEN_HEIGHT)) ? XW'(SCREEN_HEIGHT) : XW'(ye_q);
      end
      CMD_GLYPH: begin
        xstop_s = XW'(xf_q) + XW'(fw_q);
        ystop_s = XW'(yf_q) + XW'(fh_q);
      end
      CMD_STR_CHAR: begin
        xs_s    = XW'(cur_col_q);
        ys_s    = XW'(cur_row_q);
        xstop_s = XW'(cur_col_q) + XW'(fw_q);
        ystop_s = XW'(cur_row_q) + XW'(fh_q);
      end
      default: ;
    endcase
  end

  // Cursor wrap at the right edge, then at the bottom
  always_comb begin
    col_a = cur_col_q;
    row_a = cur_row_q;
    if ((12'(cur_col_q) + 12'(fw_q)) > 12'(SCREEN_WIDTH)) begin
      col_a = 11'(org_col_q);
      row_a = cur_row_q + 11'(fh_q);
    end
    if ((12'(row_a) + 12'(fh_q)) > 12'(SCREEN_HEIGHT)) begin
      col_a = 11'(org_col_q);
      row_a = 11'(org_row_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q      <= 6'd8;
      fh_q      <= 6'd8;
      cur_col_q <= '0;
      cur_row_q <= '0;
      org_col_q <= '0;
      org_row_q <= '0;
      pv_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_e'(cfg_index_i))
          CFG_FONT_WIDTH:  fw_q <= cfg_data_i;
          CFG_FONT_HEIGHT: fh_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (ctl_i.prep && cmd_q == CMD_STR_CHAR) begin
        cur_col_q <= col_a;
        cur_row_q <= row_a;
      end
      if (ctl_i.setup && cmd_q == CMD_STR_START) begin
        org_col_q <= xf_q;
        org_row_q <= yf_q;
        cur_col_q <= 11'(xf_q);
        cur_row_q <= 11'(yf_q);
      end
      if (ctl_i.finish && cmd_q == CMD_STR_CHAR) begin
        cur_col_q <= cur_col_q + 11'(fw_q);
      end
      pv_q <= ctl_i.step;
    end
  end

  // Item, loop and result registers
  always_ff @(posedge clk_i) begin
    gsize_q <= 10'(row_bytes) * 10'(fh_q);
    if (ctl_i.load) begin
      cmd_q      <= cmd_e'(command_i);
      xf_q       <= x_first_i;
      yf_q       <= y_first_i;
      xe_q       <= x_end_i;
      ye_q       <= y_end_i;
      fore_q     <= colour_fore_i;
      back_q     <= colour_back_i;
      clr_q      <= see_through_i;
      code_q     <= char_code_i;
      gaddr_q    <= glyph_address_i;
      gbyte_in_q <= glyph_byte_i;
    end
    if (ctl_i.clr_setup) begin
      x_q       <= '0;
      xs_q      <= '0;
      xstop_q   <= XW'(SCREEN_WIDTH);
      y_q       <= '0;
      ystop_q   <= XW'(SCREEN_HEIGHT);
      rowbase_q <= '0;
      c_q       <= '0;
      pcol_q    <= '0;
      gmode_q   <= 1'b0;
    end
    if (ctl_i.setup) begin
      x_q       <= xs_s;
      xs_q      <= xs_s;
      xstop_q   <= xstop_s;
      y_q       <= ys_s;
      ystop_q   <= ystop_s;
      rowbase_q <= RBW'(ys_s) * RBW'(SCREEN_WIDTH);
      gptr_q    <= GPW'(code_q - 8'(FirstCode)) * GPW'(gsize_q);
      c_q       <= '0;
      pcol_q    <= fore_q;
      gmode_q   <= (cmd_q == CMD_GLYPH) || (cmd_q == CMD_STR_CHAR);
    end
    if (ctl_i.check) skip_q <= skip_now;
    if (ctl_i.step) begin
      if (x_wrap) begin
        x_q       <= xs_q;
        c_q       <= '0;
        y_q       <= y_q + 1'b1;
        rowbase_q <= rowbase_q + RBW'(SCREEN_WIDTH);
        gptr_q    <= gptr_q + GPW'(row_bytes);
      end else begin
        x_q <= x_q + 1'b1;
        c_q <= c_q + 1'b1;
      end
    end
    // Write stage registers the loop position and feeds the framebuffer in the cycle after the loop step
    pa_q     <= FAW'(rowbase_q + RBW'(x_q));
    pin_q    <= (x_q < XW'(SCREEN_WIDTH)) && (y_q < XW'(SCREEN_HEIGHT));
    pbit_q   <= c_q[2:0];
    pglyph_q <= gmode_q;
    if (ctl_i.finish) begin
      pixel_q  <= (cmd_q == CMD_READ && rd_on_screen) ? frd_q : 16'd0;
      status_q <= (cmd_q == CMD_GLOAD && !gaddr_ok) ||
                  (cmd_q == CMD_READ && !rd_on_screen) ||
                  (gmode_q && skip_q);
    end
  end

  // Glyph memory: load write, one byte read per loop step
  always_ff @(posedge clk_i) begin
    if (ctl_i.setup && cmd_q == CMD_GLOAD && gaddr_ok) begin
      gmem[GAW'(gaddr_q)] <= gbyte_in_q;
    end
    gbyte_q <= gmem[GAW'(gptr_q + GPW'(c_q[5:3]))];
  end

  assign wr_bit = gbyte_q[3'd7 - pbit_q];
  assign we     = pv_q && pin_q && (!pglyph_q || wr_bit || !clr_q);
  assign wdata  = pglyph_q ? (wr_bit ? fore_q : back_q) : pcol_q;

  // Framebuffer: one pixel write and one read port, stored byte-swapped
  always_ff @(posedge clk_i) begin
    if (we) fmem[pa_q] <= swap16(wdata);
    if (ctl_i.rd) frd_q <= fmem[FAW'(rowbase_q + RBW'(xf_q))];
  end

  assign pixel_value_o = pixel_q;
  assign status_o      = status_q;

endmodule
